// ===== rtl/xcfp_pkg.sv =====
// Shared types and constants of the XOR checked frame parser.
`timescale 1ns / 1ps

package xcfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned PairW    = 7;
  localparam int unsigned CfgIdxW  = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHeader   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegQueryOne = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOpenSlot = 3'd2;
  localparam logic [CfgIdxW-1:0] RegQueryAll = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBeat     = 3'd4;

  // Frame verdicts
  localparam logic [VerdictW-1:0] VerdictOk      = 3'd0;
  localparam logic [VerdictW-1:0] VerdictCsumBad = 3'd1;
  localparam logic [VerdictW-1:0] VerdictUnknown = 3'd2;
  localparam logic [VerdictW-1:0] VerdictShort   = 3'd3;
  localparam logic [VerdictW-1:0] VerdictRefused = 3'd4;

  // Result kinds
  localparam logic KindPair    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] header_value;
    logic [ByteW-1:0] code_query_one;
    logic [ByteW-1:0] code_open_slot;
    logic [ByteW-1:0] code_query_all;
    logic [ByteW-1:0] code_heartbeat;
  } cfg_t;

  typedef struct packed {
    logic                result_kind;
    logic [ByteW-1:0]    command_code;
    logic [ByteW-1:0]    slot_number;
    logic [ByteW-1:0]    slot_state;
    logic [VerdictW-1:0] verdict;
    logic [PairW-1:0]    pair_count;
    logic                last;
  } res_t;

endpackage

// ===== rtl/xcfp_cfg_regs.sv =====
// Configuration registers: frame header byte and command codes.
`timescale 1ns / 1ps

module xcfp_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [xcfp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [xcfp_pkg::ByteW-1:0]        cfg_wdata_i,
  output xcfp_pkg::cfg_t                    cfg_o
);

  xcfp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        xcfp_pkg::RegHeader:   cfg_d.header_value   = cfg_wdata_i;
        xcfp_pkg::RegQueryOne: cfg_d.code_query_one = cfg_wdata_i;
        xcfp_pkg::RegOpenSlot: cfg_d.code_open_slot = cfg_wdata_i;
        xcfp_pkg::RegQueryAll: cfg_d.code_query_all = cfg_wdata_i;
        xcfp_pkg::RegBeat:     cfg_d.code_heartbeat = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value   <= 8'hAA;
      cfg_q.code_query_one <= 8'd1;
      cfg_q.code_open_slot <= 8'd2;
      cfg_q.code_query_all <= 8'd3;
      cfg_q.code_heartbeat <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/xcfp_parser.sv =====
// Frame state machine: hunts for the header, tracks the frame and forms results.
`timescale 1ns / 1ps

module xcfp_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [xcfp_pkg::ByteW-1:0] rx_byte_i,
  input  xcfp_pkg::cfg_t             cfg_i,
  output logic                       res_valid_o,
  output xcfp_pkg::res_t             res_o
);

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhCmd     = 3'd1,
    PhLen     = 3'd2,
    PhPayload = 3'd3,
    PhCheck   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ClsOne  = 3'd0,
    ClsOpen = 3'd1,
    ClsAll  = 3'd2,
    ClsBeat = 3'd3,
    ClsNone = 3'd4
  } cls_e;

  phase_e                     phase_q, phase_d;
  logic [xcfp_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic [xcfp_pkg::ByteW-1:0] len_q, len_d;
  logic [xcfp_pkg::ByteW-1:0] idx_q, idx_d;
  logic [xcfp_pkg::ByteW-1:0] xor_q, xor_d;
  logic [xcfp_pkg::ByteW-1:0] slot_q, slot_d;
  logic [xcfp_pkg::ByteW-1:0] state_q, state_d;
  logic [xcfp_pkg::ByteW-1:0] idx_inc;
  cls_e                       cls;
  logic                       is_all;

  // Priority match of the command byte against the code registers
  always_comb begin
    if (cmd_q == cfg_i.code_query_one) begin
      cls = ClsOne;
    end else if (cmd_q == cfg_i.code_open_slot) begin
      cls = ClsOpen;
    end else if (cmd_q == cfg_i.code_query_all) begin
      cls = ClsAll;
    end else if (cmd_q == cfg_i.code_heartbeat) begin
      cls = ClsBeat;
    end else begin
      cls = ClsNone;
    end
  end

  assign is_all  = (cls == ClsAll);
  assign idx_inc = idx_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    idx_d       = idx_q;
    xor_d       = xor_q;
    slot_d      = slot_q;
    state_d     = state_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.command_code = cmd_q;

    if (accept_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == cfg_i.header_value) begin
            xor_d   = rx_byte_i;
            phase_d = PhCmd;
          end
        end
        PhCmd: begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PhLen;
        end
        PhLen: begin
          len_d   = rx_byte_i;
          idx_d   = '0;
          slot_d  = '0;
          state_d = '0;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = (rx_byte_i == '0) ? PhCheck : PhPayload;
        end
        PhPayload: begin
          xor_d = xor_q ^ rx_byte_i;
          if (!idx_q[0]) begin
            if (is_all || idx_q == '0) slot_d = rx_byte_i;
          end else begin
            if (is_all || idx_q == 8'd1) state_d = rx_byte_i;
            // Emit each query-all pair as soon as its state byte lands
            if (is_all) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = xcfp_pkg::KindPair;
              res_o.slot_number = slot_q;
              res_o.slot_state  = rx_byte_i;
            end
          end
          idx_d = idx_inc;
          if (idx_inc == len_q) phase_d = PhCheck;
        end
        PhCheck: begin
          phase_d           = PhHunt;
          xor_d             = '0;
          res_valid_o       = 1'b1;
          res_o.result_kind = xcfp_pkg::KindSummary;
          res_o.last        = 1'b1;
          if (rx_byte_i != xor_q) begin
            res_o.verdict = xcfp_pkg::VerdictCsumBad;
          end else begin
            case (cls) inside
              ClsOne, ClsOpen: begin
                if (len_q < 8'd2) begin
                  res_o.verdict = xcfp_pkg::VerdictShort;
                end else begin
                  res_o.slot_number = slot_q;
                  res_o.slot_state  = state_q;
                  res_o.verdict     = (cls == ClsOpen && state_q != '0) ?
                                      xcfp_pkg::VerdictRefused : xcfp_pkg::VerdictOk;
                end
              end
              ClsAll:  res_o.pair_count = len_q[xcfp_pkg::ByteW-1:1];
              ClsBeat: res_o.verdict    = xcfp_pkg::VerdictOk;
              default: res_o.verdict    = xcfp_pkg::VerdictUnknown;
            endcase
          end
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cmd_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      xor_q   <= '0;
      slot_q  <= '0;
      state_q <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      xor_q   <= xor_d;
      slot_q  <= slot_d;
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/xcfp_out_buf.sv =====
// Result output register with a skid stage; the input side waits on out_stall only while the skid stage is full.
`timescale 1ns / 1ps

module xcfp_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xcfp_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output xcfp_pkg::res_t out_data_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  xcfp_pkg::res_t out_data_q, out_data_d;
  xcfp_pkg::res_t skid_data_q, skid_data_d;
  logic           pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        // advance the skid entry; no push can arrive while it is full
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_data_d = push_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_data_d  = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/xor_checked_frame_parser.sv =====
// Top level of the XOR checked frame parser.
`timescale 1ns / 1ps

// Byte-serial deframer for header / command / length / payload / XOR checksum
// frames. It takes one byte per clock cycle while in_stall_o is low, and each
// byte is handled in the cycle it is accepted: the frame state updates and any
// result is registered in the output register, or in the skid stage while the
// output register holds a stalled result. Query-all frames give one pair result
// per payload pair, then every frame ends in one summary with a verdict. The
// output register is backed by a one-entry skid stage; in_stall_o rises only
// when both hold results, and is driven from a register. Configuration writes
// take effect at the next edge and belong to idle periods.
module xor_checked_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xcfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [xcfp_pkg::ByteW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [xcfp_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [xcfp_pkg::ByteW-1:0]    command_code_o,
  output logic [xcfp_pkg::ByteW-1:0]    slot_number_o,
  output logic [xcfp_pkg::ByteW-1:0]    slot_state_o,
  output logic [xcfp_pkg::VerdictW-1:0] verdict_o,
  output logic [xcfp_pkg::PairW-1:0]    pair_count_o,
  output logic                          last_o
);

  xcfp_pkg::cfg_t cfg;
  xcfp_pkg::res_t res;
  xcfp_pkg::res_t out_data;
  logic           res_valid;
  logic           full;
  logic           accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  xcfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  xcfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  xcfp_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign result_kind_o  = out_data.result_kind;
  assign command_code_o = out_data.command_code;
  assign slot_number_o  = out_data.slot_number;
  assign slot_state_o   = out_data.slot_state;
  assign verdict_o      = out_data.verdict;
  assign pair_count_o   = out_data.pair_count;
  assign last_o         = out_data.last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the XOR checked frame parser.
`timescale 1ns / 1ps

module testbench;
  import xcfp_pkg::*;

  typedef enum logic [2:0] {PhHunt, PhCmd, PhLen, PhPayload, PhCheck} parse_phase_e;
  typedef enum logic [2:0] {ClsQueryOne, ClsOpen, ClsQueryAll, ClsBeat, ClsNone} cmd_class_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = RegHeader;
  logic [ByteW-1:0]    cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    rx_byte   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                res_kind;
  logic [ByteW-1:0]    res_cmd;
  logic [ByteW-1:0]    res_slot;
  logic [ByteW-1:0]    res_state;
  logic [VerdictW-1:0] res_verdict;
  logic [PairW-1:0]    res_pairs;
  logic                res_last;

  // Mirror of the parser registers and frame state
  cfg_t               reg_model;
  parse_phase_e       frame_phase = PhHunt;
  logic [ByteW-1:0]   frame_cmd   = '0;
  logic [ByteW-1:0]   pay_len     = '0;
  logic [ByteW-1:0]   pay_idx     = '0;
  logic [ByteW-1:0]   run_xor     = '0;
  logic [ByteW-1:0]   held_slot   = '0;
  logic [ByteW-1:0]   held_state  = '0;

  logic [ByteW-1:0]   bytes_to_send[$];
  res_t               results_due[$];

  int mismatch_count    = 0;
  int bytes_accepted    = 0;
  int frame_bytes_queued = 0;
  int gap_left          = 0;
  int stall_left        = 0;
  bit idle_on           = 1'b1;
  bit calm              = 1'b0;
  bit drain_hold        = 1'b0;
  bit drained_once      = 1'b0;

  xor_checked_frame_parser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (res_kind),
    .command_code_o (res_cmd),
    .slot_number_o  (res_slot),
    .slot_state_o   (res_state),
    .verdict_o      (res_verdict),
    .pair_count_o   (res_pairs),
    .last_o         (res_last)
  );

  always #2 clk = ~clk;

  function automatic cmd_class_e classify(input logic [ByteW-1:0] c);
    if (c == reg_model.code_query_one) return ClsQueryOne;
    if (c == reg_model.code_open_slot) return ClsOpen;
    if (c == reg_model.code_query_all) return ClsQueryAll;
    if (c == reg_model.code_heartbeat) return ClsBeat;
    return ClsNone;
  endfunction

  function automatic res_t make_res(input logic kind, input logic [ByteW-1:0] slot,
                                    input logic [ByteW-1:0] st,
                                    input logic [VerdictW-1:0] verdict,
                                    input logic [PairW-1:0] pairs);
    res_t r;
    r.result_kind  = kind;
    r.command_code = frame_cmd;
    r.slot_number  = slot;
    r.slot_state   = st;
    r.verdict      = verdict;
    r.pair_count   = pairs;
    r.last         = kind;
    return r;
  endfunction

  // Advance the frame state by one accepted byte and queue what it produces
  function automatic void parse_byte(input logic [ByteW-1:0] b);
    cmd_class_e cls;
    cls = classify(frame_cmd);
    case (frame_phase)
      PhHunt: begin
        if (b == reg_model.header_value) begin
          run_xor     = b;
          frame_phase = PhCmd;
        end
      end
      PhCmd: begin
        frame_cmd   = b;
        run_xor     = run_xor ^ b;
        frame_phase = PhLen;
      end
      PhLen: begin
        pay_len     = b;
        pay_idx     = '0;
        held_slot   = '0;
        held_state  = '0;
        run_xor     = run_xor ^ b;
        frame_phase = (b == '0) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        run_xor = run_xor ^ b;
        if (!pay_idx[0]) begin
          if (cls == ClsQueryAll || pay_idx == 8'd0) held_slot = b;
        end else begin
          if (cls == ClsQueryAll || pay_idx == 8'd1) held_state = b;
          if (cls == ClsQueryAll) results_due.push_back(make_res(KindPair, held_slot, b,
                                                                  VerdictOk, '0));
        end
        pay_idx = pay_idx + 8'd1;
        if (pay_idx == pay_len) frame_phase = PhCheck;
      end
      default: begin
        frame_phase = PhHunt;
        if (b != run_xor) begin
          results_due.push_back(make_res(KindSummary, '0, '0, VerdictCsumBad, '0));
        end else if (cls == ClsQueryOne || cls == ClsOpen) begin
          if (pay_len < 8'd2)
            results_due.push_back(make_res(KindSummary, '0, '0, VerdictShort, '0));
          else if (cls == ClsOpen && held_state != '0)
            results_due.push_back(make_res(KindSummary, held_slot, held_state,
                                           VerdictRefused, '0));
          else
            results_due.push_back(make_res(KindSummary, held_slot, held_state,
                                           VerdictOk, '0));
        end else if (cls == ClsQueryAll) begin
          results_due.push_back(make_res(KindSummary, '0, '0, VerdictOk, pay_len[7:1]));
        end else if (cls == ClsBeat) begin
          results_due.push_back(make_res(KindSummary, '0, '0, VerdictOk, '0));
        end else begin
          results_due.push_back(make_res(KindSummary, '0, '0, VerdictUnknown, '0));
        end
        run_xor = '0;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got = {res_kind, res_cmd, res_slot, res_state, res_verdict, res_pairs, res_last};
    if (results_due.size() == 0) begin
      flag_mismatch($sformatf("result 0x%0h with nothing outstanding", got));
      return;
    end
    want = results_due.pop_front();
    compare_field("result_kind", got.result_kind, want.result_kind);
    compare_field("command_code", got.command_code, want.command_code);
    compare_field("slot_number", got.slot_number, want.slot_number);
    compare_field("slot_state", got.slot_state, want.slot_state);
    compare_field("verdict", got.verdict, want.verdict);
    compare_field("pair_count", got.pair_count, want.pair_count);
    compare_field("last", got.last, want.last);
  endtask

  // Byte sender: hold a stalled request, otherwise idle in bursts or send the next byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (drain_hold && results_due.size() == 0) drain_hold = 1'b0;
      if (in_valid && !in_stall) begin
        parse_byte(rx_byte);
        bytes_accepted++;
        if (!calm && results_due.size() > 0 &&
            ((!drained_once && bytes_accepted >= 150) || $urandom_range(0, 199) == 0)) begin
          drain_hold   = 1'b1;
          drained_once = 1'b1;
        end
      end
      if (!in_valid || !in_stall) begin
        if (drain_hold) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (bytes_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          gap_left = $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b1;
          rx_byte  <= bytes_to_send.pop_front();
        end
      end
    end
  end

  // Result receiver: check each accepted result and stall in bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build header, command, length, body and checksum; keep only the first cut bytes when 0 < cut < frame size
  task automatic queue_frame(input logic [ByteW-1:0] cmd, input logic [ByteW-1:0] body[$],
                             input bit bad_sum, input int cut);
    logic [ByteW-1:0] frame[$];
    logic [ByteW-1:0] sum;
    int n;
    frame.push_back(reg_model.header_value);
    frame.push_back(cmd);
    frame.push_back(8'(body.size()));
    foreach (body[i]) frame.push_back(body[i]);
    sum = '0;
    foreach (frame[i]) sum = sum ^ frame[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    frame.push_back(sum);
    n = (cut > 0 && cut < frame.size()) ? cut : frame.size();
    for (int i = 0; i < n; i++) bytes_to_send.push_back(frame[i]);
    frame_bytes_queued += n;
  endtask

  task automatic random_traffic(input int target);
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] cmd;
    int start;
    int len;
    int sel;
    int cut;
    start = frame_bytes_queued;
    while (frame_bytes_queued - start < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // line noise between frames
        repeat ($urandom_range(1, 3)) bytes_to_send.push_back(pick_byte());
      end else begin
        case ($urandom_range(0, 9)) inside
          0, 1:    cmd = reg_model.code_query_one;
          2, 3:    cmd = reg_model.code_open_slot;
          4, 5, 6: cmd = reg_model.code_query_all;
          7:       cmd = reg_model.code_heartbeat;
          default: cmd = pick_byte();
        endcase
        sel = $urandom_range(0, 99);
        if (sel == 0)     len = $urandom_range(200, 255);
        else if (sel < 16) len = $urandom_range(0, 1);
        else if (sel < 70) len = $urandom_range(2, 6);
        else               len = $urandom_range(7, 24);
        body.delete();
        repeat (len) body.push_back(pick_byte());
        cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, len + 3) : 0;
        queue_frame(cmd, body, $urandom_range(0, 9) == 0, cut);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  // Drain, then close any open frame so register writes land between frames
  task automatic settle();
    wait_idle();
    while (frame_phase != PhHunt) begin
      bytes_to_send.push_back(~reg_model.header_value);
      wait_idle();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      RegHeader:   reg_model.header_value   = val;
      RegQueryOne: reg_model.code_query_one = val;
      RegOpenSlot: reg_model.code_open_slot = val;
      RegQueryAll: reg_model.code_query_all = val;
      default:     reg_model.code_heartbeat = val;
    endcase
  endtask

  task automatic write_all(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] one,
                           input logic [ByteW-1:0] open, input logic [ByteW-1:0] all,
                           input logic [ByteW-1:0] beat);
    write_reg(RegHeader, hdr);
    write_reg(RegQueryOne, one);
    write_reg(RegOpenSlot, open);
    write_reg(RegQueryAll, all);
    write_reg(RegBeat, beat);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] shared;
    logic [ByteW-1:0] other;
    reg_model.header_value   = 8'hAA;
    reg_model.code_query_one = 8'h01;
    reg_model.code_open_slot = 8'h02;
    reg_model.code_query_all = 8'h03;
    reg_model.code_heartbeat = 8'h04;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset register values
    bytes_to_send.push_back(8'h55);
    body.delete();
    queue_frame(reg_model.code_heartbeat, body, 1'b1, 0);
    body.push_back(8'hFF);
    queue_frame(reg_model.code_query_one, body, 1'b0, 0);
    body.delete();
    body.push_back(8'h00);
    body.push_back(8'hFF);
    queue_frame(reg_model.code_open_slot, body, 1'b0, 0);
    body.push_back(8'h80);
    queue_frame(reg_model.code_query_all, body, 1'b0, 0);
    body.delete();
    queue_frame(8'hFF, body, 1'b0, 0);

    // Longest query-all frames drive the pair count to its top
    repeat (255) body.push_back(pick_byte());
    queue_frame(reg_model.code_query_all, body, 1'b0, 0);
    void'(body.pop_back());
    queue_frame(reg_model.code_query_all, body, 1'b0, 0);
    random_traffic(150);
    settle();

    write_all(8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F);
    random_traffic(170);
    settle();

    idle_on = 1'b0;
    write_all(8'hFF, 8'h00, 8'hFF, 8'h01, 8'h55);
    random_traffic(170);
    settle();
    idle_on = 1'b1;

    // All command codes equal: query-one wins
    shared = 8'($urandom_range(0, 255));
    write_all(8'($urandom_range(0, 255)), shared, shared, shared, shared);
    random_traffic(170);
    settle();

    shared = 8'($urandom_range(0, 255));
    other  = 8'($urandom_range(0, 255));
    write_all(8'($urandom_range(0, 255)), shared, other, other, shared);
    random_traffic(170);
    settle();

    repeat (2) begin
      write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      random_traffic(170);
      settle();
    end

    calm = 1'b1;
    write_all(8'hAA, 8'h01, 8'h02, 8'h03, 8'h04);
    random_traffic(170);
    settle();
    repeat (6) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== xor_checked_frame_parser.f =====
rtl/xcfp_pkg.sv
rtl/xcfp_cfg_regs.sv
rtl/xcfp_parser.sv
rtl/xcfp_out_buf.sv
rtl/xor_checked_frame_parser.sv
tb/testbench.sv
